>>> rtl/assert_macros.svh
// Assertion helpers; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication
`define CHK_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

>>> rtl/mlfrp_pkg.sv
`timescale 1ns / 1ps
package mlfrp_pkg;

	localparam int MAX_EXTENSIONS = 11;

	localparam logic [7:0] START_CHAR = 8'h68;
	localparam logic [7:0] STOP_CHAR  = 8'h16;
	localparam logic [7:0] CI_A       = 8'h72;
	localparam logic [7:0] CI_B       = 8'h76;
	localparam logic [3:0] CTRL_NIB   = 4'h8;
	localparam logic [7:0] DIF_END_A  = 8'h0F;
	localparam logic [7:0] DIF_END_B  = 8'h1F;
	localparam logic [7:0] DIF_FILL   = 8'h2F;
	localparam logic [6:0] HINT_MASK  = 7'h7A;
	localparam logic [6:0] HINT_VAL   = 7'h6A;
	localparam logic [6:0] HINT_ALT   = 7'h39;
	localparam logic [3:0] COD_LVAR   = 4'hD;
	localparam logic [3:0] COD_SPEC   = 4'hF;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HDR, PH_PRE, PH_DIF, PH_DIFE, PH_VIF, PH_VIFE,
		PH_LVAR, PH_DATA, PH_END, PH_CS, PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_RECORD = 2'd0, KIND_ACCEPT = 2'd1, KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0, ERR_HEADER = 3'd1, ERR_CHECKSUM = 3'd2, ERR_STOP = 3'd3,
		ERR_CONTROL = 3'd4, ERR_CI = 3'd5, ERR_RECORD = 3'd6, ERR_TRUNC = 3'd7
	} err_t;

	typedef struct packed {
		logic [2:0]  frame_error;
		logic [63:0] record_value;
		logic [7:0]  data_length;
		logic [3:0]  data_coding;
		logic        datetime_hint;
		logic [6:0]  value_info;
		logic [10:0] subunit_number;
		logic [21:0] tariff_number;
		logic [44:0] storage_number;
		logic [1:0]  function_code;
		logic [1:0]  result_kind;
	} result_t;

	// data bytes per coding nibble
	function automatic logic [7:0] coding_len(input logic [3:0] c);
		logic [7:0] n;
		case (c)
			4'h1, 4'h9: n = 8'd1;
			4'h2, 4'hA: n = 8'd2;
			4'h3, 4'hB: n = 8'd3;
			4'h4, 4'h5, 4'hC: n = 8'd4;
			4'h6, 4'hE: n = 8'd6;
			4'h7: n = 8'd8;
			default: n = 8'd0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/mlfrp_core.sv
`timescale 1ns / 1ps
module mlfrp_core import mlfrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q, ph, nx_phase;
	logic [8:0]  pos_q, pos, nx_pos;
	logic [7:0]  flen_q, flen, nx_flen;
	logic [7:0]  sum_q, sum, nx_sum;
	logic [47:0] hdr_q, hdr, nx_hdr;
	logic [7:0]  dif_q, dif, nx_dif;
	logic [3:0]  ext_q, ext, nx_ext;
	logic [44:0] stor_q, stor, nx_stor;
	logic [21:0] tar_q, tar, nx_tar;
	logic [10:0] sub_q, sub, nx_sub;
	logic [6:0]  vif_q, vif, nx_vif;
	logic        hint_q, hint, nx_hint;
	logic [7:0]  left_q, left, nx_left;
	logic [63:0] val_q, val, nx_val;
	logic [63:0] wgt_q, wgt, nx_wgt;
	logic [7:0]  rlen_q, rlen, nx_rlen;

	logic        emit, verd, rec_err;
	kind_t       vkind;
	err_t        verr;
	logic [7:0]  uidx, didx;
	logic [3:0]  ext1;
	logic [63:0] v1, w1;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0; flen_q <= '0; sum_q <= '0; hdr_q <= '0; dif_q <= '0;
			ext_q <= '0; stor_q <= '0; tar_q <= '0; sub_q <= '0; vif_q <= '0;
			hint_q <= 1'b0; left_q <= '0; val_q <= '0; wgt_q <= 64'd1; rlen_q <= '0;
		end else if (step) begin
			phase_q <= nx_phase;
			pos_q <= nx_pos; flen_q <= nx_flen; sum_q <= nx_sum; hdr_q <= nx_hdr;
			dif_q <= nx_dif; ext_q <= nx_ext; stor_q <= nx_stor; tar_q <= nx_tar;
			sub_q <= nx_sub; vif_q <= nx_vif; hint_q <= nx_hint; left_q <= nx_left;
			val_q <= nx_val; wgt_q <= nx_wgt; rlen_q <= nx_rlen;
		end
	end

	// start of frame restarts from the reset values
	always_comb begin
		if (frame_start) begin
			ph = PH_HDR;
			pos = '0; flen = '0; sum = '0; hdr = '0; dif = '0; ext = '0;
			stor = '0; tar = '0; sub = '0; vif = '0; hint = 1'b0; left = '0;
			val = '0; wgt = 64'd1; rlen = '0;
		end else begin
			ph = phase_q;
			pos = pos_q; flen = flen_q; sum = sum_q; hdr = hdr_q; dif = dif_q;
			ext = ext_q; stor = stor_q; tar = tar_q; sub = sub_q; vif = vif_q;
			hint = hint_q; left = left_q; val = val_q; wgt = wgt_q; rlen = rlen_q;
		end
	end

	// per-byte parse step
	always_comb begin
		nx_phase = ph; nx_pos = pos; nx_flen = flen; nx_sum = sum; nx_hdr = hdr;
		nx_dif = dif; nx_ext = ext; nx_stor = stor; nx_tar = tar; nx_sub = sub;
		nx_vif = vif; nx_hint = hint; nx_left = left; nx_val = val; nx_wgt = wgt;
		nx_rlen = rlen;
		emit = 1'b0; verd = 1'b0; rec_err = 1'b0;
		vkind = KIND_REJECT; verr = ERR_NONE;
		uidx = pos[7:0] - 8'd4;
		didx = rlen - left;
		ext1 = ext + 4'd1;
		v1 = '0; w1 = '0;

		unique case (ph)
			PH_IDLE: ;
			PH_HDR: begin
				if (pos == 9'd1) nx_flen = data_byte;
				if ((pos == 9'd0 && data_byte != START_CHAR) ||
				    (pos == 9'd2 && data_byte != flen) ||
				    (pos == 9'd3 && data_byte != START_CHAR)) begin
					verd = 1'b1; verr = ERR_HEADER;
				end else if (pos == 9'd3 && flen < 8'd16) begin
					verd = 1'b1; verr = ERR_CI;
				end else begin
					if (pos == 9'd3) nx_phase = PH_PRE;
					nx_pos = pos + 9'd1;
				end
			end
			PH_CS: begin
				if (data_byte != sum) begin
					verd = 1'b1; verr = ERR_CHECKSUM;
				end else nx_phase = PH_STOP;
			end
			PH_STOP: begin
				verd = 1'b1;
				if (data_byte != STOP_CHAR) verr = ERR_STOP;
				else vkind = KIND_ACCEPT;
			end
			default: begin
				nx_sum = sum + data_byte;
				if (ph == PH_PRE) begin
					if (uidx == 8'd0 && data_byte[3:0] != CTRL_NIB) begin
						verd = 1'b1; verr = ERR_CONTROL;
					end else if (uidx == 8'd2 && data_byte != CI_A && data_byte != CI_B) begin
						verd = 1'b1; verr = ERR_CI;
					end else begin
						case (uidx)
							8'd3: nx_hdr[23:16] = data_byte;
							8'd4: nx_hdr[31:24] = data_byte;
							8'd5: nx_hdr[39:32] = data_byte;
							8'd6: nx_hdr[47:40] = data_byte;
							8'd11: nx_hdr[15:8] = data_byte;
							8'd12: nx_hdr[7:0] = data_byte;
							8'd14: nx_phase = PH_DIF;
							default: ;
						endcase
					end
				end else begin
					case (ph)
						PH_DIF: begin
							if (data_byte == DIF_END_A || data_byte == DIF_END_B)
								nx_phase = PH_END;
							else if (data_byte != DIF_FILL) begin
								nx_dif = data_byte;
								nx_stor = {44'd0, data_byte[6]};
								nx_tar = '0; nx_sub = '0; nx_hint = 1'b0;
								nx_ext = '0; nx_rlen = '0;
								nx_phase = data_byte[7] ? PH_DIFE : PH_VIF;
							end
						end
						PH_DIFE: begin
							for (int i = 0; i < MAX_EXTENSIONS; i++) begin
								if (ext == 4'(i)) begin
									nx_sub[i] = data_byte[6];
									nx_tar[2*i +: 2] = data_byte[5:4];
									nx_stor[1+4*i +: 4] = data_byte[3:0];
								end
							end
							nx_ext = ext1;
							if (data_byte[7]) begin
								if (ext1 >= 4'(MAX_EXTENSIONS)) rec_err = 1'b1;
							end else nx_phase = PH_VIF;
						end
						PH_VIF, PH_VIFE: begin
							if (ph == PH_VIF) begin
								nx_vif = data_byte[6:0];
								nx_ext = '0;
							end else begin
								if ((data_byte[6:0] & HINT_MASK) == HINT_VAL ||
								    data_byte[6:0] == HINT_ALT)
									nx_hint = 1'b1;
								nx_ext = ext1;
							end
							if (data_byte[7]) begin
								if (ph == PH_VIF) nx_phase = PH_VIFE;
								else if (ext1 >= 4'(MAX_EXTENSIONS)) rec_err = 1'b1;
							end else begin
								nx_val = '0; nx_wgt = 64'd1;
								if (dif[3:0] == COD_SPEC) nx_phase = PH_DIF;
								else if (dif[3:0] == COD_LVAR) nx_phase = PH_LVAR;
								else begin
									nx_rlen = coding_len(dif[3:0]);
									if (nx_rlen == 8'd0) emit = 1'b1;
									else begin
										nx_left = nx_rlen;
										nx_phase = PH_DATA;
									end
								end
							end
						end
						PH_LVAR: begin
							nx_rlen = data_byte;
							if (data_byte == 8'd0) emit = 1'b1;
							else begin
								nx_left = data_byte;
								nx_phase = PH_DATA;
							end
						end
						PH_DATA: begin
							if ((dif[3:0] >= 4'h9 && dif[3:0] <= 4'hC) || dif[3:0] == 4'hE) begin
								// two BCD digits, low nibble first
								v1 = val; w1 = wgt;
								if (data_byte[3:0] <= 4'd9) begin
									v1 = val + wgt * {60'd0, data_byte[3:0]};
									w1 = {wgt[60:0], 3'b0} + {wgt[62:0], 1'b0};
								end
								nx_val = v1; nx_wgt = w1;
								if (data_byte[7:4] <= 4'd9) begin
									nx_val = v1 + w1 * {60'd0, data_byte[7:4]};
									nx_wgt = {w1[60:0], 3'b0} + {w1[62:0], 1'b0};
								end
							end else if (dif[3:0] != COD_LVAR && didx < 8'd8)
								nx_val = val | ({56'd0, data_byte} << {didx[2:0], 3'b000});
							nx_left = left - 8'd1;
							if (nx_left == 8'd0) emit = 1'b1;
						end
						default: ;
					endcase
				end

				if (rec_err) begin
					verd = 1'b1; verr = ERR_RECORD;
				end else if (!verd) begin
					if (emit) nx_phase = PH_DIF;
					nx_pos = pos + 9'd1;
					if ({1'b0, uidx} + 9'd1 >= {1'b0, flen}) begin
						if (nx_phase != PH_DIF && nx_phase != PH_END) begin
							verd = 1'b1; verr = ERR_TRUNC;
						end else nx_phase = PH_CS;
					end
				end
			end
		endcase
		if (verd) nx_phase = PH_IDLE;
	end

	// result assembly
	always_comb begin
		res = '0;
		res_valid = (verd || emit) && step;
		if (verd) begin
			res.result_kind  = vkind;
			res.record_value = {16'd0, nx_hdr};
			res.frame_error  = verr;
		end else begin
			res.result_kind    = KIND_RECORD;
			res.function_code  = nx_dif[5:4];
			res.storage_number = nx_stor;
			res.tariff_number  = nx_tar;
			res.subunit_number = nx_sub;
			res.value_info     = nx_vif;
			res.datetime_hint  = nx_hint;
			res.data_coding    = nx_dif[3:0];
			res.data_length    = nx_rlen;
			res.record_value   = nx_val;
		end
	end

endmodule

>>> rtl/mbus_long_frame_record_parser.sv
`timescale 1ns / 1ps
// M-Bus long-frame record parser.
// Slave side: one received frame byte per beat in s_tdata, s_tuser high on
// the first byte of a frame (restarts the parser, dropping any open frame).
// Master side: at most one result per input byte. m_tuser is the kind:
// data record, frame accepted or frame rejected. Records come out before the
// verdict, so a receiver drops the records of a rejected frame.
// Path: a byte lands in the input register and is parsed combinationally
// when the output register can take its result; the result is loaded into
// the output register, which drives m_tvalid.
// Throughput: one byte per clock unless stalled, set by the single parse step.
// Reset: the parser goes idle and ignores bytes until a frame start; both
// registers empty.
// Stall: while the output register holds an untaken result the input register
// keeps its byte and s_tready drops once it is occupied, so nothing is lost.
`include "assert_macros.svh"
module mbus_long_frame_record_parser import mlfrp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // frame_start
	output logic         m_tvalid,
	input  logic         m_tready,
	// function_code, storage_number, tariff_number, subunit_number, value_info,
	// datetime_hint, data_coding, data_length, record_value, frame_error, pad
	output logic [167:0] m_tdata,
	output logic [1:0]   m_tuser    // result_kind
);

	logic       in_v_s1, start_s1, step, core_v;
	logic [7:0] byte_s1;
	logic       res_v_s2;
	result_t    core_res, res_s2;

	assign step     = in_v_s1 && (!res_v_s2 || m_tready);
	assign s_tready = !in_v_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_v_s1 <= 1'b0;
		else if (s_tready) in_v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	mlfrp_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step),
		.data_byte(byte_s1), .frame_start(start_s1),
		.res_valid(core_v), .res(core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_s2 <= 1'b0;
		else if (step && core_v) res_v_s2 <= 1'b1;
		else if (m_tready) res_v_s2 <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (step && core_v) res_s2 <= core_res;
	end

	assign m_tvalid = res_v_s2;
	assign m_tuser  = res_s2.result_kind;
	assign m_tdata  = {1'b0, res_s2[168:2]};

	`CHK_IMPL(a_rec_no_err, m_tvalid && m_tuser == KIND_RECORD, res_s2.frame_error == ERR_NONE)
	`CHK_IMPL(a_verdict_clean, m_tvalid && m_tuser != KIND_RECORD,
		res_s2.function_code == 2'd0 && res_s2.data_length == 8'd0)
	`CHK_IMPL(a_kind_legal, m_tvalid, m_tuser != 2'd3)
	`CHK_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(res_s2))

endmodule

>>> tb/mlfrp_checker.sv
`timescale 1ns / 1ps
module mlfrp_checker import mlfrp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [167:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           fail_count,
	output int           pending_count
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  func;
		logic [44:0] storage;
		logic [21:0] tariff;
		logic [10:0] subunit;
		logic [6:0]  vif;
		logic        hint;
		logic [3:0]  coding;
		logic [7:0]  len;
		logic [63:0] value;
		logic [2:0]  err;
	} parsed_t;

	parsed_t expected_q[$];

	// parser copy
	phase_t      phase;
	logic [8:0]  pos;
	logic [7:0]  flen;
	logic [7:0]  csum;
	logic [47:0] hdr;
	logic [7:0]  dif;
	logic [3:0]  ext_n;
	logic [44:0] stor;
	logic [21:0] tar;
	logic [10:0] sub;
	logic [6:0]  vif;
	logic        hint;
	logic [7:0]  left;
	logic [63:0] acc;
	logic [63:0] weight;
	logic [7:0]  rlen;

	function automatic logic [7:0] bytes_for(input logic [3:0] c);
		case (c)
			4'h1, 4'h9: return 8'd1;
			4'h2, 4'hA: return 8'd2;
			4'h3, 4'hB: return 8'd3;
			4'h4, 4'h5, 4'hC: return 8'd4;
			4'h6, 4'hE: return 8'd6;
			4'h7: return 8'd8;
			default: return 8'd0;
		endcase
	endfunction

	// append one expectation at the tail
	function automatic void queue_expect(input parsed_t p);
		expected_q = {expected_q, p};
	endfunction

	task automatic clear_state();
		phase = PH_IDLE; pos = 0; flen = 0; csum = 0; hdr = 0; dif = 0;
		ext_n = 0; stor = 0; tar = 0; sub = 0; vif = 0; hint = 0; left = 0;
		acc = 0; weight = 1; rlen = 0;
	endtask

	task automatic push_verdict(input kind_t k, input err_t e);
		parsed_t p;
		p = '0;
		p.kind = k;
		p.value = {16'd0, hdr};
		p.err = e;
		queue_expect(p);
		phase = PH_IDLE;
	endtask

	function automatic void push_record();
		parsed_t p;
		p.kind = KIND_RECORD;
		p.func = dif[5:4];
		p.storage = stor;
		p.tariff = tar;
		p.subunit = sub;
		p.vif = vif;
		p.hint = hint;
		p.coding = dif[3:0];
		p.len = rlen;
		p.value = acc;
		p.err = ERR_NONE;
		queue_expect(p);
		phase = PH_DIF;
	endfunction

	function automatic void add_digit(input logic [3:0] d);
		if (d <= 4'd9) begin
			acc = acc + 64'(d) * weight;
			weight = weight * 64'd10;
		end
	endfunction

	function automatic void close_vif();
		acc = 0;
		weight = 1;
		if (dif[3:0] == COD_SPEC) begin
			phase = PH_DIF;
		end else if (dif[3:0] == COD_LVAR) begin
			phase = PH_LVAR;
		end else begin
			rlen = bytes_for(dif[3:0]);
			if (rlen == 0) begin
				push_record();
			end else begin
				left = rlen;
				phase = PH_DATA;
			end
		end
	endfunction

	// returns 1 on a record error
	function automatic bit record_step(input logic [7:0] b);
		logic [7:0] at;
		case (phase)
			PH_DIF: begin
				if (b == DIF_END_A || b == DIF_END_B) begin
					phase = PH_END;
				end else if (b != DIF_FILL) begin
					dif = b; stor = 45'(b[6]); tar = 0; sub = 0; hint = 0;
					ext_n = 0; rlen = 0;
					phase = b[7] ? PH_DIFE : PH_VIF;
				end
			end
			PH_DIFE: begin
				if (ext_n < 11) begin
					sub[ext_n] = b[6];
					tar[2*ext_n +: 2] = b[5:4];
					stor[1 + 4*ext_n +: 4] = b[3:0];
				end
				ext_n = ext_n + 1;
				if (b[7]) begin
					if (ext_n >= MAX_EXTENSIONS) return 1;
				end else phase = PH_VIF;
			end
			PH_VIF: begin
				vif = b[6:0];
				ext_n = 0;
				if (b[7]) phase = PH_VIFE;
				else close_vif();
			end
			PH_VIFE: begin
				if ((b[6:0] & HINT_MASK) == HINT_VAL || b[6:0] == HINT_ALT) hint = 1;
				ext_n = ext_n + 1;
				if (b[7]) begin
					if (ext_n >= MAX_EXTENSIONS) return 1;
				end else close_vif();
			end
			PH_LVAR: begin
				rlen = b;
				if (b == 0) push_record();
				else begin
					left = b;
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				at = rlen - left;
				if ((dif[3:0] >= 4'h9 && dif[3:0] <= 4'hC) || dif[3:0] == 4'hE) begin
					add_digit(b[3:0]);
					add_digit(b[7:4]);
				end else if (dif[3:0] != COD_LVAR && at < 8) begin
					acc[8*at[2:0] +: 8] = b;
				end
				left = left - 1;
				if (left == 0) push_record();
			end
			default: ;
		endcase
		return 0;
	endfunction

	task automatic take_byte(input logic [7:0] b, input logic start);
		logic [7:0] ui;
		if (start) begin
			clear_state();
			phase = PH_HDR;
		end
		case (phase)
			PH_IDLE: return;
			PH_HDR: begin
				if (pos == 0 && b != START_CHAR) begin push_verdict(KIND_REJECT, ERR_HEADER); return; end
				if (pos == 1) flen = b;
				if (pos == 2 && b != flen) begin push_verdict(KIND_REJECT, ERR_HEADER); return; end
				if (pos == 3) begin
					if (b != START_CHAR) begin push_verdict(KIND_REJECT, ERR_HEADER); return; end
					if (flen < 16) begin push_verdict(KIND_REJECT, ERR_CI); return; end
					phase = PH_PRE;
				end
				pos = pos + 1;
				return;
			end
			PH_CS: begin
				if (b != csum) push_verdict(KIND_REJECT, ERR_CHECKSUM);
				else phase = PH_STOP;
				return;
			end
			PH_STOP: begin
				if (b != STOP_CHAR) push_verdict(KIND_REJECT, ERR_STOP);
				else push_verdict(KIND_ACCEPT, ERR_NONE);
				return;
			end
			default: ;
		endcase
		// user byte
		ui = 8'(pos - 9'd4);
		csum = csum + b;
		if (phase == PH_PRE) begin
			if (ui == 0 && b[3:0] != CTRL_NIB) begin push_verdict(KIND_REJECT, ERR_CONTROL); return; end
			if (ui == 2 && b != CI_A && b != CI_B) begin push_verdict(KIND_REJECT, ERR_CI); return; end
			if (ui >= 3 && ui <= 6) hdr[16 + 8*(ui-3) +: 8] = b;
			if (ui == 11) hdr[15:8] = b;
			if (ui == 12) hdr[7:0] = b;
			if (ui == 14) phase = PH_DIF;
		end else if (record_step(b)) begin
			push_verdict(KIND_REJECT, ERR_RECORD);
			return;
		end
		pos = pos + 1;
		if (9'(ui) + 9'd1 >= 9'(flen)) begin
			if (phase != PH_DIF && phase != PH_END) push_verdict(KIND_REJECT, ERR_TRUNC);
			else phase = PH_CS;
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic compare_beat();
		parsed_t w;
		if (expected_q.size() == 0) begin
			report("unexpected beat", 64'(m_tuser), 0);
			return;
		end
		w = expected_q.pop_front();
		if (m_tuser != w.kind) report("result_kind", 64'(m_tuser), 64'(w.kind));
		if (m_tdata[1:0] != w.func) report("function_code", 64'(m_tdata[1:0]), 64'(w.func));
		if (m_tdata[46:2] != w.storage) report("storage_number", 64'(m_tdata[46:2]), 64'(w.storage));
		if (m_tdata[68:47] != w.tariff) report("tariff_number", 64'(m_tdata[68:47]), 64'(w.tariff));
		if (m_tdata[79:69] != w.subunit) report("subunit_number", 64'(m_tdata[79:69]), 64'(w.subunit));
		if (m_tdata[86:80] != w.vif) report("value_info", 64'(m_tdata[86:80]), 64'(w.vif));
		if (m_tdata[87] != w.hint) report("datetime_hint", 64'(m_tdata[87]), 64'(w.hint));
		if (m_tdata[91:88] != w.coding) report("data_coding", 64'(m_tdata[91:88]), 64'(w.coding));
		if (m_tdata[99:92] != w.len) report("data_length", 64'(m_tdata[99:92]), 64'(w.len));
		if (m_tdata[163:100] != w.value) report("record_value", m_tdata[163:100], w.value);
		if (m_tdata[166:164] != w.err) report("frame_error", 64'(m_tdata[166:164]), 64'(w.err));
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
		clear_state();
	end

	// output side first, so a same-edge expectation is not consumed early
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) compare_beat();
			if (s_tvalid && s_tready) take_byte(s_tdata, s_tuser);
		end
		pending_count = expected_q.size();
	end

endmodule

>>> tb/tb_mbus_long_frame_record_parser.sv
`timescale 1ns / 1ps
module tb_mbus_long_frame_record_parser;
	import mlfrp_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // data_byte
	logic         s_tuser;   // frame_start
	logic         m_tvalid;
	logic         m_tready;
	logic [167:0] m_tdata;   // function_code .. frame_error, pad
	logic [1:0]   m_tuser;   // result_kind
	int           fail_count;
	int           pending_count;
	int           cycle_count;
	int           sent_count;

	// frame under construction
	logic [7:0]   frame_buf[$];
	bit           stop_rand;

	mbus_long_frame_record_parser i_dut (.*);

	mlfrp_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// add one byte at the end of the frame
	function automatic void append_byte(input logic [7:0] b);
		frame_buf = {frame_buf, b};
	endfunction

	// receiver stalls
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			m_tready <= 1;
			n = $urandom_range(1, 30);
			repeat (n) @(posedge clk);
			n = stop_rand ? 0 : gap_len();
			if (n > 0) begin
				m_tready <= 0;
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		int g;
		s_tvalid <= 1;
		s_tdata <= b;
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		sent_count++;
		g = stop_rand ? 0 : gap_len();
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_frame_buf();
		foreach (frame_buf[i]) send_byte(frame_buf[i], i == 0);
	endtask

	// one random record into frame_buf
	task automatic add_record(input logic [3:0] cod, input int n_dife, input int n_vife);
		logic [7:0] d;
		int ln;
		d = 8'($urandom);
		d[3:0] = cod;
		d[7] = n_dife > 0;
		if (d == DIF_END_A || d == DIF_END_B || d == DIF_FILL) d[5:4] = 2'b00;
		if (d == DIF_END_A || d == DIF_END_B || d == DIF_FILL) d[6] = 1;
		append_byte(d);
		for (int i = 0; i < n_dife; i++) begin
			d = 8'($urandom);
			d[7] = i < n_dife - 1;
			append_byte(d);
		end
		d = 8'($urandom);
		d[7] = n_vife > 0;
		append_byte(d);
		for (int i = 0; i < n_vife; i++) begin
			d = $urandom_range(0, 3) == 0 ? 8'h6A + 8'($urandom_range(0, 1) * 16) : 8'($urandom);
			d[7] = i < n_vife - 1;
			append_byte(d);
		end
		if (cod == COD_LVAR) begin
			ln = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			append_byte(8'(ln));
		end else ln = (cod == COD_SPEC) ? 0 : int'(i_checker.bytes_for(cod));
		for (int i = 0; i < ln; i++) begin
			d = ($urandom_range(0, 1) && cod >= 4'h9) ? {4'($urandom_range(0, 9)),
				4'($urandom_range(0, 9))} : 8'($urandom);
			append_byte(d);
		end
	endtask

	// builds a frame; corrupt selects a fault, 0 for a clean frame
	task automatic build_frame(input int n_rec, input int corrupt);
		logic [7:0] sum;
		int l;
		frame_buf = {};
		for (int i = 0; i < 15; i++) append_byte(8'($urandom));
		frame_buf[0][3:0] = CTRL_NIB;
		frame_buf[2] = $urandom_range(0, 1) ? CI_A : CI_B;
		for (int i = 0; i < n_rec; i++) begin
			case ($urandom_range(0, 9))
				0: append_byte(DIF_FILL);
				default: add_record(4'($urandom), $urandom_range(0, 3) == 0 ?
					$urandom_range(1, 10) : 0, $urandom_range(0, 3) == 0 ?
					$urandom_range(1, 10) : 0);
			endcase
		end
		if ($urandom_range(0, 2) == 0) begin
			append_byte($urandom_range(0, 1) ? DIF_END_A : DIF_END_B);
			repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
		end
		if (corrupt == 1) void'(frame_buf.pop_back());
		if (corrupt == 2) frame_buf[0][3:0] = 4'($urandom_range(0, 7));
		if (corrupt == 3) frame_buf[2] = 8'h70;
		if (corrupt == 4) add_record(4'h1, 12, 0);
		if (corrupt == 5) add_record(4'h1, 0, 12);
		if (frame_buf.size() > 255) frame_buf = frame_buf[0:254];
		l = frame_buf.size();
		sum = 0;
		foreach (frame_buf[i]) sum += frame_buf[i];
		if (corrupt == 6) sum = sum + 1;
		append_byte(sum);
		append_byte(corrupt == 7 ? 8'h61 : STOP_CHAR);
		frame_buf.push_front(START_CHAR);
		frame_buf.push_front(corrupt == 8 ? 8'(l + 1) : 8'(l));
		frame_buf.push_front(8'(l));
		frame_buf.push_front(corrupt == 9 ? 8'h00 : START_CHAR);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		sent_count = 0;
		stop_rand = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle noise, short frame, bad header, clean frames of each coding
		send_byte(8'hFF, 0);
		send_byte(8'h00, 0);
		send_frame_buf();
		frame_buf = {START_CHAR, 8'h0F, 8'h0F, START_CHAR};
		send_frame_buf();
		frame_buf = {START_CHAR, 8'h20, 8'h21};
		send_frame_buf();
		frame_buf = {8'h00};
		send_frame_buf();
		for (int c = 0; c < 16; c++) begin
			build_frame(0, 0);
			frame_buf = frame_buf[0:frame_buf.size() - 3];
			// replace tail: one record of coding c, plus checksum/stop rebuilt
			void'(frame_buf.pop_front()); void'(frame_buf.pop_front());
			void'(frame_buf.pop_front()); void'(frame_buf.pop_front());
			add_record(4'(c), c == 3 ? 10 : 0, c == 4 ? 10 : 0);
			begin
				logic [7:0] s;
				int l;
				s = 0;
				foreach (frame_buf[i]) s += frame_buf[i];
				l = frame_buf.size();
				append_byte(s);
				append_byte(STOP_CHAR);
				frame_buf.push_front(START_CHAR);
				frame_buf.push_front(8'(l));
				frame_buf.push_front(8'(l));
				frame_buf.push_front(START_CHAR);
			end
			send_frame_buf();
		end
		// hold off the sender until everything has come out
		s_tvalid <= 0;
		stop_rand = 1;
		wait_drained();
		stop_rand = 0;

		// random frames: mostly well formed, some faults, some restarts and noise
		while (sent_count < 1250) begin
			int r;
			r = $urandom_range(0, 19);
			build_frame($urandom_range(0, 5), r < 10 ? 0 : r - 9);
			if (r == 19) begin
				frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 1)];
				for (int i = 0; i < frame_buf.size(); i++) frame_buf[i] = 8'($urandom);
			end
			send_frame_buf();
			if (r == 18) send_byte(8'($urandom), 0);
			if (sent_count > 600 && sent_count < 700) begin
				stop_rand = 1;
				s_tvalid <= 0;
				wait_drained();
				stop_rand = 0;
			end
		end
		s_tvalid <= 0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
